// ----- rtl/srsw_pkg.sv -----
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and constants of the selective-repeat sender window
// Event and result codes, register indexes, port widths and the command and
// status records between the controller and the datapath.
// ----------------------------------------------------------------------------
package srsw_pkg;

	localparam int RESULT_LIMIT = 32;
	localparam int SEQ_W        = 16;
	localparam int WIN_W        = 6;
	localparam int CFG_ADDR_W   = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int IN_DATA_W    = 24;
	localparam int OUT_DATA_W   = 40;
	localparam int USER_W       = 2;

	localparam logic [CFG_ADDR_W-1:0] CFG_WIN_LEN       = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_PACKETS = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

	localparam logic [WIN_W-1:0]      WINDOW_RESET  = 6'd8;
	localparam logic [SEQ_W-1:0]      TOTAL_RESET   = 16'd0;
	localparam logic [SEQ_W-1:0]      TIMEOUT_RESET = 16'd100;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_SEND  = 2'd1,
		FUNC_ACK   = 2'd2,
		FUNC_TICK  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_NEW  = 2'd1,
		KIND_RETX = 2'd2,
		KIND_DONE = 2'd3
	} kind_t;

	typedef struct packed {
		logic load_in;
		logic clear;
		logic send;
		logic mark;
		logic slide_first;
		logic slide_step;
		logic slide_end;
		logic tick;
		logic walk_init;
		logic walk_adv;
		logic walk_take;
		logic walk_emit_take;
		logic walk_final;
		logic emit_idle;
	} ctrl_cmd_t;

	typedef struct packed {
		func_t func;
		logic  done;
		logic  send_ok;
		logic  ack_ok;
		logic  ack_in_win;
		logic  ack_is_base;
		logic  timer_on;
		logic  expire;
		logic  slide_more;
		logic  walk_at_end;
		logic  walk_acked;
		logic  pend_valid;
		logic  out_free;
	} dp_status_t;

endpackage

// ----- rtl/selective_repeat_sender_window.sv -----
// ----------------------------------------------------------------------------
// selective_repeat_sender_window: sender side of a selective-repeat window
// Issues new and retransmitted sequence numbers for control events and
// slides the window base over acknowledged slots.
//
//   Channel   Direction  Beat contents
//   s_*       in         tuser: func; tdata: ack_seq, ack_good
//   m_*       out        tuser: kind; tdata: seq, final_chunk, window_base; tlast
//   cfg_*     in         register writes: win_len, total_packets, timeout_ticks
//
// A new packet goes from the evaluation state straight to the output register;
// any other event with a single plain result passes through the emit state. An
// acknowledgement of the base slides the base on over further acknowledged
// slots. A timeout walks the window one slot per cycle unless a stalled output
// holds it. Reset clears the window state and loads register defaults. A stalled
// output holds the controller; at most one event is in flight.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window #(
	parameter int MAX_WINDOW = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [srsw_pkg::IN_DATA_W-1:0]       s_tdata,   // ack_seq[15:0], ack_good[16]
	input  logic [srsw_pkg::USER_W-1:0]          s_tuser,   // func[1:0]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [srsw_pkg::OUT_DATA_W-1:0]      m_tdata,   // seq[15:0], final_chunk[16],
	                                                        // window_base[32:17]
	output logic [srsw_pkg::USER_W-1:0]          m_tuser,   // kind[1:0]
	output logic                                 m_tlast,
	input  logic                                 cfg_we,
	input  logic [srsw_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [srsw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import srsw_pkg::*;

	ctrl_cmd_t         cmd;
	dp_status_t        sts;
	logic [1:0]        out_kind;
	logic [SEQ_W-1:0]  out_seq;
	logic              out_final;
	logic [SEQ_W-1:0]  out_base;

	srsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srsw_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_func     (s_tuser[1:0]),
		.in_ack_seq  (s_tdata[SEQ_W-1:0]),
		.in_ack_good (s_tdata[SEQ_W]),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_kind    (out_kind),
		.out_seq     (out_seq),
		.out_final   (out_final),
		.out_base    (out_base),
		.out_last    (m_tlast)
	);

	assign m_tuser = out_kind;
	assign m_tdata = {(OUT_DATA_W - 2 * SEQ_W - 1)'(0), out_base, out_final, out_seq};

endmodule

// ----- rtl/srsw_ctrl.sv -----
// ----------------------------------------------------------------------------
// srsw_ctrl: sequencing controller of the sender window
// Takes one event at a time, decides its handling from datapath status, steps
// the base slide and retransmission walk one slot per cycle unless stalled.
// ----------------------------------------------------------------------------
module srsw_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  srsw_pkg::dp_status_t   sts,
	output srsw_pkg::ctrl_cmd_t    cmd
);
	import srsw_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SLIDE,
		ST_WALK,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				priority if (sts.func == FUNC_START) begin
					cmd.clear = 1'b1;
					state_d   = ST_EMIT;
				end else if (sts.done) begin
					state_d = ST_EMIT;
				end else begin
					unique case (sts.func)
						FUNC_SEND: begin
							if (!sts.send_ok) begin
								state_d = ST_EMIT;
							end else if (sts.out_free) begin
								cmd.send = 1'b1;
								state_d  = ST_IDLE;
							end
						end
						FUNC_ACK: begin
							priority if (sts.ack_ok && sts.ack_in_win) begin
								cmd.mark = 1'b1;
								state_d  = ST_EMIT;
							end else if (sts.ack_ok && sts.ack_is_base) begin
								cmd.slide_first = 1'b1;
								state_d         = ST_SLIDE;
							end else begin
								state_d = ST_EMIT;
							end
						end
						FUNC_TICK: begin
							priority if (!sts.timer_on) begin
								state_d = ST_EMIT;
							end else if (!sts.expire) begin
								cmd.tick = 1'b1;
								state_d  = ST_EMIT;
							end else begin
								cmd.walk_init = 1'b1;
								state_d       = ST_WALK;
							end
						end
						default: begin
							state_d = ST_EMIT;
						end
					endcase
				end
			end
			ST_SLIDE: begin
				if (sts.slide_more) begin
					cmd.slide_step = 1'b1;
				end else begin
					cmd.slide_end = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_WALK: begin
				priority if (sts.walk_at_end) begin
					if (!sts.pend_valid) begin
						state_d = ST_EMIT;
					end else if (sts.out_free) begin
						cmd.walk_final = 1'b1;
						state_d        = ST_IDLE;
					end
				end else if (sts.walk_acked) begin
					cmd.walk_adv = 1'b1;
				end else if (!sts.pend_valid) begin
					cmd.walk_take = 1'b1;
				end else begin
					if (sts.out_free) begin
						cmd.walk_emit_take = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_idle = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/srsw_dp.sv -----
// ----------------------------------------------------------------------------
// srsw_dp: datapath of the sender window
// Holds the registers, the window state, the acknowledged bitmap, the walk
// cursor and the output register, and reports status to the controller.
// ----------------------------------------------------------------------------
module srsw_dp #(
	parameter int MAX_WINDOW = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  srsw_pkg::ctrl_cmd_t              cmd,
	output srsw_pkg::dp_status_t             sts,
	input  logic [1:0]                       in_func,
	input  logic [srsw_pkg::SEQ_W-1:0]       in_ack_seq,
	input  logic                             in_ack_good,
	input  logic                             cfg_we,
	input  logic [srsw_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [srsw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [1:0]                       out_kind,
	output logic [srsw_pkg::SEQ_W-1:0]       out_seq,
	output logic                             out_final,
	output logic [srsw_pkg::SEQ_W-1:0]       out_base,
	output logic                             out_last
);
	import srsw_pkg::*;

	localparam int SLOT_W  = $clog2(MAX_WINDOW);
	localparam int EFF_MAX = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;
	localparam logic [WIN_W-1:0]  EFF_MAX_W = WIN_W'(EFF_MAX);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WINDOW - 1);
	localparam logic [SLOT_W:0]   SLOT_WRAP = (SLOT_W + 1)'(MAX_WINDOW);

	logic [WIN_W-1:0]      win_q;
	logic [SEQ_W-1:0]      total_q;
	logic [SEQ_W-1:0]      tmo_q;

	func_t                 func_q;
	logic [SEQ_W-1:0]      ack_q;
	logic                  good_q;

	logic [SEQ_W-1:0]      base_q;
	logic [SLOT_W-1:0]     base_slot_q;
	logic [SEQ_W-1:0]      next_q;
	logic [SEQ_W-1:0]      elapsed_q;
	logic                  timer_q;
	logic [MAX_WINDOW-1:0] acked_q;

	logic [SEQ_W-1:0]      lim_q;
	logic [SEQ_W-1:0]      cur_q;
	logic [SLOT_W-1:0]     cur_slot_q;
	logic [SEQ_W-1:0]      pend_q;
	logic                  pend_valid_q;

	logic                  out_valid_q;
	kind_t                 out_kind_q;
	logic [SEQ_W-1:0]      out_seq_q;
	logic                  out_final_q;
	logic [SEQ_W-1:0]      out_base_q;
	logic                  out_last_q;

	logic [WIN_W-1:0]      eff_win;
	logic [SEQ_W:0]        base_plus_w;
	logic [SEQ_W-1:0]      span_end;
	logic [SEQ_W-1:0]      ack_off;
	logic [SLOT_W:0]       ack_slot_sum;
	logic [SLOT_W-1:0]     ack_slot;
	logic [SLOT_W-1:0]     base_slot_inc;
	logic [SLOT_W-1:0]     cur_slot_inc;
	logic [SEQ_W-1:0]      elapsed_inc;
	logic [SEQ_W-1:0]      tmo_lim;
	logic                  out_free;
	logic                  emit;
	logic [SEQ_W:0]        next_plus1;
	logic [SEQ_W:0]        pend_plus1;

	always_comb begin
		priority if (win_q == '0) begin
			eff_win = WIN_W'(1);
		end else if (win_q > EFF_MAX_W) begin
			eff_win = EFF_MAX_W;
		end else begin
			eff_win = win_q;
		end
	end

	assign base_plus_w   = {1'b0, base_q} + (SEQ_W + 1)'(eff_win);
	assign span_end      = (base_plus_w < {1'b0, total_q}) ? base_plus_w[SEQ_W-1:0] : total_q;
	assign ack_off       = ack_q - base_q;
	assign ack_slot_sum  = {1'b0, base_slot_q} + {1'b0, ack_off[SLOT_W-1:0]};
	assign ack_slot      = (ack_slot_sum >= SLOT_WRAP) ? SLOT_W'(ack_slot_sum - SLOT_WRAP)
	                                                   : ack_slot_sum[SLOT_W-1:0];
	assign base_slot_inc = (base_slot_q == SLOT_LAST) ? '0 : base_slot_q + SLOT_W'(1);
	assign cur_slot_inc  = (cur_slot_q == SLOT_LAST) ? '0 : cur_slot_q + SLOT_W'(1);
	assign elapsed_inc   = (elapsed_q == '1) ? elapsed_q : elapsed_q + SEQ_W'(1);
	assign tmo_lim       = (tmo_q == '0) ? SEQ_W'(1) : tmo_q;
	assign out_free      = !out_valid_q || out_ready;
	assign next_plus1    = {1'b0, next_q} + (SEQ_W + 1)'(1);
	assign pend_plus1    = {1'b0, pend_q} + (SEQ_W + 1)'(1);
	assign emit          = cmd.send || cmd.walk_emit_take || cmd.walk_final || cmd.emit_idle;

	always_comb begin
		sts             = '0;
		sts.func        = func_q;
		sts.done        = (base_q >= total_q);
		sts.send_ok     = (next_q >= base_q) && (next_q < span_end);
		sts.ack_ok      = good_q && (ack_q < total_q);
		sts.ack_in_win  = (ack_q > base_q) && ({1'b0, ack_q} < base_plus_w);
		sts.ack_is_base = (ack_q == base_q);
		sts.timer_on    = timer_q;
		sts.expire      = (elapsed_inc >= tmo_lim);
		sts.slide_more  = (base_q < lim_q) && acked_q[base_slot_q];
		sts.walk_at_end = (cur_q >= lim_q);
		sts.walk_acked  = acked_q[cur_slot_q];
		sts.pend_valid  = pend_valid_q;
		sts.out_free    = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= WINDOW_RESET;
			total_q <= TOTAL_RESET;
			tmo_q   <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_WIN_LEN:       win_q   <= cfg_wdata[WIN_W-1:0];
				CFG_TOTAL_PACKETS: total_q <= cfg_wdata;
				CFG_TIMEOUT_TICKS: tmo_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= func_t'(in_func);
			ack_q  <= in_ack_seq;
			good_q <= in_ack_good;
		end
		if (cmd.slide_first || cmd.walk_init) begin
			lim_q <= span_end;
		end
		if (cmd.walk_init) begin
			cur_q      <= base_q;
			cur_slot_q <= base_slot_q;
		end else if (cmd.walk_adv || cmd.walk_take || cmd.walk_emit_take) begin
			cur_q      <= cur_q + SEQ_W'(1);
			cur_slot_q <= cur_slot_inc;
		end
		if (cmd.walk_take || cmd.walk_emit_take) begin
			pend_q <= cur_q;
		end
		if (emit) begin
			out_base_q <= base_q;
			priority if (cmd.send) begin
				out_kind_q  <= KIND_NEW;
				out_seq_q   <= next_q;
				out_final_q <= (total_q != '0) && (next_plus1 == {1'b0, total_q});
				out_last_q  <= 1'b1;
			end else if (cmd.walk_emit_take || cmd.walk_final) begin
				out_kind_q  <= KIND_RETX;
				out_seq_q   <= pend_q;
				out_final_q <= (total_q != '0) && (pend_plus1 == {1'b0, total_q});
				out_last_q  <= cmd.walk_final;
			end else begin
				out_kind_q  <= (base_q >= total_q) ? KIND_DONE : KIND_NONE;
				out_seq_q   <= '0;
				out_final_q <= 1'b0;
				out_last_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			base_slot_q  <= '0;
			next_q       <= '0;
			elapsed_q    <= '0;
			timer_q      <= 1'b0;
			acked_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				base_q      <= '0;
				base_slot_q <= '0;
				next_q      <= '0;
				elapsed_q   <= '0;
				timer_q     <= 1'b0;
				acked_q     <= '0;
			end
			if (cmd.mark) begin
				acked_q[ack_slot] <= 1'b1;
			end
			if (cmd.slide_first || cmd.slide_step) begin
				acked_q[base_slot_q] <= 1'b0;
				base_q               <= base_q + SEQ_W'(1);
				base_slot_q          <= base_slot_inc;
			end
			if (cmd.slide_end) begin
				if (next_q < base_q) begin
					next_q <= base_q;
				end
				elapsed_q <= '0;
				timer_q   <= 1'b1;
			end
			if (cmd.send) begin
				next_q <= next_plus1[SEQ_W-1:0];
				if (!timer_q) begin
					timer_q   <= 1'b1;
					elapsed_q <= '0;
				end
			end
			if (cmd.tick) begin
				elapsed_q <= elapsed_inc;
			end
			if (cmd.walk_init) begin
				elapsed_q    <= '0;
				pend_valid_q <= 1'b0;
			end else if (cmd.walk_take || cmd.walk_emit_take) begin
				pend_valid_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_seq   = out_seq_q;
	assign out_final = out_final_q;
	assign out_base  = out_base_q;
	assign out_last  = out_last_q;

endmodule

// ----- rtl/srsw_checker.sv -----
// ----------------------------------------------------------------------------
// srsw_port_checks: port-level checks of the sender window
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module srsw_port_checks (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [srsw_pkg::OUT_DATA_W-1:0]      m_tdata,
	input logic [srsw_pkg::USER_W-1:0]          m_tuser,
	input logic                                 m_tlast
);
	import srsw_pkg::*;

	// A stalled output beat holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output beat changed while stalled");

	// Only one event is handled at a time.
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// A beat without a packet carries no sequence number and ends its run.
	a_plain_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_DONE)
			|-> m_tdata[SEQ_W:0] == '0 && m_tlast)
		else $error("plain result carries a sequence number or is not last");

	// A new packet is always the only result of its event.
	a_new_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_NEW |-> m_tlast)
		else $error("new packet result not marked last");

endmodule

bind selective_repeat_sender_window srsw_port_checks u_srsw_checker (.*);
